FILE: hdl/qdm_pkg.sv
// qdm_pkg: shared types and constants of the quoted delimiter masker
// used by qdm_cfg_regs, qdm_scan and quoted_delimiter_masker_unit; no dependencies
package qdm_pkg;

  localparam int MaxDelimitersDefault = 4;
  localparam int MaxDelimitersHw      = 4;
  localparam int AddrWidth            = 5;
  localparam int DataWidth            = 32;

  localparam logic [7:0] DQuote = 8'h22;
  localparam logic [7:0] SQuote = 8'h27;

  localparam logic [7:0] BeginAliasReset = 8'd254;
  localparam logic [7:0] EndAliasReset   = 8'd255;

  typedef enum logic [1:0] {
    MODE_OUT    = 2'd0,
    MODE_OPENED = 2'd1,
    MODE_IN     = 2'd2,
    MODE_THIRD  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_BEGIN_ALIAS = 3'd0,
    REG_END_ALIAS   = 3'd1,
    REG_DELIM_COUNT = 3'd2,
    REG_DELIM_A     = 3'd3,
    REG_DELIM_B     = 3'd4,
    REG_DELIM_C     = 3'd5,
    REG_DELIM_D     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       quote_error;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] begin_alias;
    logic [7:0] end_alias;
    logic [2:0] delim_count;
  } cfg_t;

  typedef struct packed {
    logic  fire;
    logic  last;
    logic  err;
    mode_e mode;
  } scan_status_t;

endpackage

FILE: hdl/qdm_cfg_regs.sv
// qdm_cfg_regs: apb register file for aliases, delimiter count and delimiters
// depends on qdm_pkg
module qdm_cfg_regs import qdm_pkg::*; #(
  parameter int MaxDelimiters = MaxDelimitersDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [AddrWidth-1:0]                paddr,
  input  logic [DataWidth-1:0]                pwdata,
  output logic [DataWidth-1:0]                prdata,
  output logic                                pready,
  output cfg_t                                cfg_o,
  output logic [MaxDelimiters-1:0][7:0]       delims_o
);

  logic [7:0]                    begin_alias_q;
  logic [7:0]                    end_alias_q;
  logic [2:0]                    delim_count_q;
  logic [MaxDelimiters-1:0][7:0] delim_q;
  logic                          wr_en;
  logic [2:0]                    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_alias_q <= BeginAliasReset;
      end_alias_q   <= EndAliasReset;
      delim_count_q <= '0;
      delim_q       <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BEGIN_ALIAS: begin_alias_q <= pwdata[7:0];
        REG_END_ALIAS:   end_alias_q   <= pwdata[7:0];
        REG_DELIM_COUNT: delim_count_q <= pwdata[2:0];
        default: begin
          // delimiter slots beyond the built count are dropped
          for (int i = 0; i < MaxDelimiters; i++) begin
            if (idx == 3'(int'(REG_DELIM_A) + i)) begin
              delim_q[i] <= pwdata[7:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_BEGIN_ALIAS: prdata[7:0] = begin_alias_q;
      REG_END_ALIAS:   prdata[7:0] = end_alias_q;
      REG_DELIM_COUNT: prdata[2:0] = delim_count_q;
      default: begin
        for (int i = 0; i < MaxDelimiters; i++) begin
          if (idx == 3'(int'(REG_DELIM_A) + i)) begin
            prdata[7:0] = delim_q[i];
          end
        end
      end
    endcase
  end

  assign cfg_o.begin_alias = begin_alias_q;
  assign cfg_o.end_alias   = end_alias_q;
  assign cfg_o.delim_count = delim_count_q;
  assign delims_o          = delim_q;

endmodule

FILE: hdl/qdm_scan.sv
// qdm_scan: input register, quote scanning fsm with delimiter compare, result register
// depends on qdm_pkg
module qdm_scan import qdm_pkg::*; #(
  parameter int MaxDelimiters = MaxDelimitersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic [MaxDelimiters-1:0][7:0] delims_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  in_t                           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output out_t                          out_data_o,
  output scan_status_t                  status_o
);

  logic       s1_valid_q;
  in_t        s1_data_q;
  logic       s2_valid_q;
  out_t       s2_data_q;
  mode_e      mode_q, mode_d;
  logic       kind_q, kind_d;
  logic       err_q, err_d;
  logic       err_new;
  logic       advance;
  logic [7:0] b;
  logic [7:0] o;
  logic [7:0] quote;
  logic [7:0] mapped;
  logic [2:0] n_eff;

  assign advance    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // delimiter compare, lowest index wins
  assign n_eff = (cfg_i.delim_count > 3'(MaxDelimiters)) ? 3'(MaxDelimiters)
                                                         : cfg_i.delim_count;
  always_comb begin
    mapped = b;
    for (int i = MaxDelimiters - 1; i >= 0; i--) begin
      if (3'(i) < n_eff && b == delims_i[i]) begin
        mapped = 8'(i + 1);
      end
    end
  end

  assign b     = s1_data_q.in_byte;
  assign quote = kind_q ? SQuote : DQuote;

  always_comb begin
    o       = b;
    mode_d  = mode_q;
    kind_d  = kind_q;
    err_new = err_q;
    if (!err_q) begin
      case (mode_q)
        MODE_OUT: begin
          if (b == DQuote || b == SQuote) begin
            kind_d = (b == SQuote);
            o      = cfg_i.begin_alias;
            mode_d = MODE_OPENED;
          end
        end
        MODE_OPENED: begin
          if (b == quote) begin
            mode_d = MODE_THIRD;
          end else begin
            o      = mapped;
            mode_d = MODE_IN;
          end
        end
        MODE_IN: begin
          if (b == quote) begin
            o      = cfg_i.end_alias;
            mode_d = MODE_OUT;
          end else begin
            o = mapped;
          end
        end
        default: begin
          if (b == quote) begin
            o      = cfg_i.end_alias;
            mode_d = MODE_OUT;
          end else begin
            err_new = 1'b1;
          end
        end
      endcase
      // unclosed run at end of line
      if (s1_data_q.line_end && !err_new && mode_d != MODE_OUT) begin
        err_new = 1'b1;
      end
    end
    err_d = err_new;
    if (s1_data_q.line_end) begin
      mode_d = MODE_OUT;
      kind_d = 1'b0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUT;
      kind_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (advance) begin
      mode_q <= mode_d;
      kind_q <= kind_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || !out_stall_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_data_q.out_byte    <= o;
      s2_data_q.quote_error <= err_new;
      s2_data_q.last        <= s1_data_q.line_end;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign out_data_o    = s2_data_q;
  assign status_o.fire = advance;
  assign status_o.last = s1_data_q.line_end;
  assign status_o.err  = err_q;
  assign status_o.mode = mode_q;

endmodule

FILE: hdl/quoted_delimiter_masker_unit.sv
// quoted_delimiter_masker_unit: top level of the quoted delimiter masker
// depends on qdm_pkg, qdm_cfg_regs and qdm_scan
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg      apb slave  psel, penable, pready     paddr, pwdata, prdata
//
// one byte a cycle sustained while the output is not stalled; input register then result register
// the scan state updates as an item leaves the input register, so items follow back to back
// a stalled output keeps its result; the input stalls only once both registers are full
// reset clears the scan state and loads the register reset values; no clearing pass
module quoted_delimiter_masker_unit import qdm_pkg::*; #(
  parameter int MaxDelimiters = MaxDelimitersDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t                          cfg;
  logic [MaxDelimiters-1:0][7:0] delims;
  scan_status_t                  status;

  qdm_cfg_regs #(
    .MaxDelimiters(MaxDelimiters)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .delims_o(delims)
  );

  qdm_scan #(
    .MaxDelimiters(MaxDelimiters)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .delims_i   (delims),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .status_o   (status)
  );

  // input back pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // error flag only rises when an item leaves the input register
  a_err_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.err) |-> $past(status.fire))
    else $error("error flag set without a transfer");

  // line end returns the scanner to its idle state
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.fire && status.last) |=> (status.mode == MODE_OUT && !status.err))
    else $error("scan state not cleared after line end");

endmodule

FILE: tb/tb_quoted_delimiter_masker_unit.sv
`timescale 1ns / 100ps
// tb_quoted_delimiter_masker_unit: self-checking bench for the quoted delimiter masker,
// with a behavioural quote scanner, random idling on both channels and apb register set-up
// depends on qdm_pkg and quoted_delimiter_masker_unit
module tb_quoted_delimiter_masker_unit;
  import qdm_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int PhaseChars   = 170;
  localparam logic [2:0] UnusedRegIdx = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_t                  in_data_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrWidth-1:0] paddr       = '0;
  logic [DataWidth-1:0] pwdata      = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_t                 out_data_o;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // register mirror and scan state of the behavioural model
  logic [7:0] cfg_begin = BeginAliasReset;
  logic [7:0] cfg_end   = EndAliasReset;
  logic [2:0] cfg_count = '0;
  logic [7:0] cfg_delim [4] = '{default: 8'h00};
  mode_e      scan_st     = MODE_OUT;
  logic       single_open = 1'b0;
  logic       quote_err   = 1'b0;

  out_t masked_due [$];
  int   send_gap_pct   = 27;
  int   recv_stall_pct = 50;
  int   n_bad          = 0;
  int   n_chars        = 0;
  int   n_checked      = 0;
  int   n_err_lines    = 0;
  int   n_lines        = 0;
  int   cycles         = 0;

  quoted_delimiter_masker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // delimiter index plus one, first match wins; counts above the hardware limit saturate
  function automatic logic [7:0] delim_code(input logic [7:0] b);
    int         active;
    logic       hit;
    logic [7:0] code;
    active = (cfg_count > MaxDelimitersDefault) ? MaxDelimitersDefault : cfg_count;
    hit    = 1'b0;
    code   = b;
    for (int i = 0; i < active; i++) begin
      if (!hit && b == cfg_delim[i]) begin
        hit  = 1'b1;
        code = 8'(i + 1);
      end
    end
    return code;
  endfunction

  function automatic out_t mask_char(input in_t c);
    out_t       r;
    logic [7:0] q;
    r.out_byte = c.in_byte;
    r.last     = c.line_end;
    q          = single_open ? SQuote : DQuote;
    if (!quote_err) begin
      case (scan_st)
        MODE_OUT: begin
          if (c.in_byte == DQuote || c.in_byte == SQuote) begin
            single_open = (c.in_byte == SQuote);
            r.out_byte  = cfg_begin;
            scan_st     = MODE_OPENED;
          end
        end
        MODE_OPENED: begin
          if (c.in_byte == q) begin
            scan_st = MODE_THIRD;
          end else begin
            r.out_byte = delim_code(c.in_byte);
            scan_st    = MODE_IN;
          end
        end
        MODE_IN: begin
          if (c.in_byte == q) begin
            r.out_byte = cfg_end;
            scan_st    = MODE_OUT;
          end else begin
            r.out_byte = delim_code(c.in_byte);
          end
        end
        default: begin
          if (c.in_byte == q) begin
            r.out_byte = cfg_end;
            scan_st    = MODE_OUT;
          end else begin
            quote_err = 1'b1;
          end
        end
      endcase
      // run still open on the final character
      if (c.line_end && scan_st != MODE_OUT) quote_err = 1'b1;
    end
    r.quote_error = quote_err;
    if (c.line_end) begin
      scan_st     = MODE_OUT;
      single_open = 1'b0;
      quote_err   = 1'b0;
    end
    return r;
  endfunction

  // result side: random stall and in-order compare
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (masked_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual byte=%02h err=%0b last=%0b",
                 $time, out_data_o.out_byte, out_data_o.quote_error, out_data_o.last);
        n_bad++;
      end else begin
        want = masked_due.pop_front();
        n_checked++;
        if (want.last) n_lines++;
        if (want.last && want.quote_error) n_err_lines++;
        if (out_data_o.out_byte !== want.out_byte) begin
          $display("%0t out_byte mismatch: expected %02h, actual %02h",
                   $time, want.out_byte, out_data_o.out_byte);
          n_bad++;
        end
        if (out_data_o.quote_error !== want.quote_error) begin
          $display("%0t quote_error mismatch: expected %0b, actual %0b",
                   $time, want.quote_error, out_data_o.quote_error);
          n_bad++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_data_o.last);
          n_bad++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic push_char(input logic [7:0] b, input logic fin);
    in_t item;
    item.in_byte  = b;
    item.line_end = fin;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    masked_due.push_back(mask_char(item));
    n_chars++;
  endtask

  // setup then access phase, then idle with psel low so transfers never share a step
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_check(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $display("%0t register %0d readback: expected %08h, actual %08h", $time, idx, want, rd);
      n_bad++;
    end
  endtask

  // upper data bits are random, only the register width should stick
  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, {24'($urandom), val}, rd);
    case (idx)
      REG_BEGIN_ALIAS: cfg_begin    = val;
      REG_END_ALIAS:   cfg_end      = val;
      REG_DELIM_COUNT: cfg_count    = val[2:0];
      REG_DELIM_A:     cfg_delim[0] = val;
      REG_DELIM_B:     cfg_delim[1] = val;
      REG_DELIM_C:     cfg_delim[2] = val;
      REG_DELIM_D:     cfg_delim[3] = val;
      default: ;
    endcase
    if (idx == REG_DELIM_COUNT) read_check(idx, {29'b0, val[2:0]});
    else if (idx <= REG_DELIM_D) read_check(idx, {24'b0, val});
  endtask

  task automatic load_config(input logic [7:0] ba, input logic [7:0] ea, input logic [7:0] cnt,
                             input logic [7:0] da, input logic [7:0] db,
                             input logic [7:0] dc, input logic [7:0] dd);
    set_reg(REG_BEGIN_ALIAS, ba);
    set_reg(REG_END_ALIAS, ea);
    set_reg(REG_DELIM_COUNT, cnt);
    set_reg(REG_DELIM_A, da);
    set_reg(REG_DELIM_B, db);
    set_reg(REG_DELIM_C, dc);
    set_reg(REG_DELIM_D, dd);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (masked_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] run_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return cfg_delim[$urandom_range(3)];
    if (r < 52) return $urandom_range(1) ? SQuote : DQuote;
    if (r < 60) return $urandom_range(1) ? 8'h00 : 8'hFF;
    return 8'($urandom);
  endfunction

  // mostly well-formed quoting with random content, some broken runs and noise
  task automatic send_line();
    logic [7:0] chars [$];
    logic [7:0] q;
    int         kind;
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(99);
      q    = $urandom_range(1) ? SQuote : DQuote;
      if (kind < 30) begin
        repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end else if (kind < 75) begin
        chars.push_back(q);
        repeat ($urandom_range(0, 5)) chars.push_back(run_byte());
        if ($urandom_range(9) != 0) chars.push_back(q);
      end else if (kind < 87) begin
        repeat (3) chars.push_back(q);
      end else if (kind < 92) begin
        chars.push_back(q);
        chars.push_back(q);
        chars.push_back(run_byte());
      end else begin
        repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom));
      end
    end
    foreach (chars[i]) push_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic test_register_reset();
    read_check(REG_BEGIN_ALIAS, {24'b0, BeginAliasReset});
    read_check(REG_END_ALIAS, {24'b0, EndAliasReset});
    read_check(REG_DELIM_COUNT, '0);
    read_check(REG_DELIM_A, '0);
    read_check(REG_DELIM_B, '0);
    read_check(REG_DELIM_C, '0);
    read_check(REG_DELIM_D, '0);
  endtask

  // count above the limit, zero byte, duplicate delimiters and a delimiter equal to a quote
  task automatic test_directed_quoting();
    load_config(BeginAliasReset, EndAliasReset, 8'd7, 8'h00, " ", DQuote, " ");
    push_char("x", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(DQuote, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(" ", 1'b0);
    push_char(SQuote, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(DQuote, 1'b0);
    // three single quotes
    push_char(SQuote, 1'b0);
    push_char(SQuote, 1'b0);
    push_char(SQuote, 1'b0);
    push_char("z", 1'b1);
    // two quotes then a stray byte, error sticks to the end of line
    push_char(DQuote, 1'b0);
    push_char(DQuote, 1'b0);
    push_char("q", 1'b0);
    push_char(DQuote, 1'b0);
    push_char(" ", 1'b1);
    // unclosed runs
    push_char(SQuote, 1'b0);
    push_char("a", 1'b1);
    push_char(DQuote, 1'b1);
    push_char("b", 1'b1);
    wait_idle();
  endtask

  task automatic test_alias_extremes();
    load_config(8'h00, 8'h00, 8'd0, " ", " ", " ", " ");
    set_reg(UnusedRegIdx, 8'h5a);
    push_char(DQuote, 1'b0);
    push_char(" ", 1'b0);
    push_char(DQuote, 1'b0);
    push_char(SQuote, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_lines(input int target);
    int stop_at;
    stop_at = n_chars + target;
    while (n_chars < stop_at) send_line();
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_quoting();
    test_alias_extremes();

    load_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 7)),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    test_random_lines(PhaseChars);

    send_gap_pct   = 50;
    recv_stall_pct = 27;
    load_config(8'hFF, 8'h00, 8'd4, 8'($urandom_range(8'h21, 8'h7e)),
                8'($urandom_range(8'h21, 8'h7e)), 8'($urandom_range(8'h21, 8'h7e)),
                8'($urandom_range(8'h21, 8'h7e)));
    test_random_lines(PhaseChars);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    load_config(8'($urandom), 8'($urandom), 8'd1, 8'($urandom_range(8'h21, 8'h7e)),
                8'($urandom), 8'($urandom), 8'($urandom));
    test_random_lines(PhaseChars);

    $display("sent %0d characters in %0d lines, %0d lines ended with a quoting error",
             n_chars, n_lines, n_err_lines);
    $display("checked %0d results over three idling phases and five register settings",
             n_checked);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
